// ===== hw/rtl/hpef_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Harmonic pair energy and force: shared types and constants
// Beat payloads, configuration register indexes and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package hpef_pkg;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic [30:0]        spring_constant;
        logic [30:0]        rest_length;
        logic               last_pair;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] force_x;
        logic signed [63:0] force_y;
        logic signed [63:0] force_z;
        logic signed [63:0] energy_total;
        logic signed [63:0] virial_xx;
        logic signed [63:0] virial_yx;
        logic signed [63:0] virial_yy;
        logic signed [63:0] virial_zx;
        logic signed [63:0] virial_zy;
        logic signed [63:0] virial_zz;
        logic               set_done;
    } t_out_item;

    typedef logic [2:0] t_cfg_index;

    localparam t_cfg_index REG_BOX_X  = 3'd0;
    localparam t_cfg_index REG_BOX_Y  = 3'd1;
    localparam t_cfg_index REG_BOX_Z  = 3'd2;
    localparam t_cfg_index REG_HALF_X = 3'd3;
    localparam t_cfg_index REG_HALF_Y = 3'd4;
    localparam t_cfg_index REG_HALF_Z = 3'd5;

    localparam logic [3:0] AXIS_X = 4'd0;
    localparam logic [3:0] AXIS_Y = 4'd1;
    localparam logic [3:0] AXIS_Z = 4'd2;

    localparam logic [3:0] JOB_KR  = 4'd0;
    localparam logic [3:0] JOB_EN  = 4'd1;
    localparam logic [3:0] JOB_FX  = 4'd2;
    localparam logic [3:0] JOB_FY  = 4'd3;
    localparam logic [3:0] JOB_FZ  = 4'd4;
    localparam logic [3:0] JOB_VXX = 4'd5;
    localparam logic [3:0] JOB_VYX = 4'd6;
    localparam logic [3:0] JOB_VYY = 4'd7;
    localparam logic [3:0] JOB_VZX = 4'd8;
    localparam logic [3:0] JOB_VZY = 4'd9;
    localparam logic [3:0] JOB_VZZ = 4'd10;

    localparam logic [4:0] ROOT_LAST = 5'd31;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FOLD,
        OP_SQUARE,
        OP_ROOT,
        OP_DIVIDE,
        OP_MUL_LOAD,
        OP_MUL_STEP,
        OP_MUL_DONE,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] sel;
        logic [4:0] step;
        logic       first;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ===== hw/rtl/hpef_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Harmonic pair datapath
// Configuration registers, minimum image folding, a shared 32 by 32 bit
// multiplier, bit-pair square root, restoring divider, sums and result beat.
// ----------------------------------------------------------------------------
module hpef_datapath #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire hpef_pkg::t_in_item   i_item,
    input  wire logic                 i_cfg_we,
    input  wire hpef_pkg::t_cfg_index i_cfg_index,
    input  wire logic [30:0]          i_cfg_data,
    input  wire hpef_pkg::t_cmd       i_cmd,
    input  wire logic                 i_out_stall,
    output hpef_pkg::t_status         o_status,
    output logic                      o_out_valid,
    output hpef_pkg::t_out_item       o_out_item
);

    localparam int Q_W = FRACTION_BITS + 1;
    localparam int U_W = FRACTION_BITS + 2;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [34:0] FOLD_LIMIT = 35'sd2147483647;

    function automatic logic signed [31:0] fold_axis(
        input logic signed [31:0] p,
        input logic signed [31:0] q,
        input logic [30:0]        box,
        input logic [30:0]        half
    );
        logic signed [34:0] d, h, l, t;
        d = 35'(q) - 35'(p);
        h = signed'({4'b0000, half});
        l = signed'({4'b0000, box});
        if (d > h) begin
            t = d - l;
        end else if (d < -h) begin
            t = d + l;
        end else begin
            t = d;
        end
        if (t > FOLD_LIMIT) begin
            fold_axis = FOLD_LIMIT[31:0];
        end else if (t < -FOLD_LIMIT) begin
            fold_axis = -FOLD_LIMIT[31:0];
        end else begin
            fold_axis = t[31:0];
        end
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] sat_add(
        input logic signed [63:0] a,
        input logic signed [63:0] b
    );
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            sat_add = s[64] ? S64_MIN : S64_MAX;
        end else begin
            sat_add = s[63:0];
        end
    endfunction

    function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
        sat_neg = (a == S64_MIN) ? S64_MAX : -a;
    endfunction

    logic [30:0]           r_box [3];
    logic [30:0]           r_half [3];
    hpef_pkg::t_in_item    r_in;
    logic signed [31:0]    r_d [3];
    logic [63:0]           r_s;
    logic [63:0]           r_root;
    logic [33:0]           r_drem;
    logic [Q_W-1:0]        r_quot;
    logic signed [U_W-1:0] r_u [3];
    logic [63:0]           r_ma;
    logic [63:0]           r_mb;
    logic                  r_mneg;
    logic [127:0]          r_acc;
    logic signed [63:0]    r_kr;
    logic signed [63:0]    r_fr;
    logic signed [63:0]    r_f [3];
    logic signed [63:0]    r_esum;
    logic signed [63:0]    r_vir [6];
    logic                  r_out_valid;
    hpef_pkg::t_out_item   r_out;

    logic signed [31:0]    fold_d [3];
    logic signed [31:0]    d_sel;
    logic [30:0]           d_mag;
    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [63:0]           mul_p;
    logic [6:0]            root_shift;
    logic [63:0]           root_bit;
    logic [63:0]           root_trial;
    logic [31:0]           den;
    logic [33:0]           div_src;
    logic                  div_ge;
    logic [33:0]           div_rem;
    logic [Q_W-1:0]        div_q;
    logic signed [U_W-1:0] div_u;
    logic signed [33:0]    rr;
    logic signed [63:0]    op_a;
    logic signed [63:0]    op_b;
    logic [6:0]            pp_shift;
    logic signed [127:0]   prod_s;
    logic signed [127:0]   prod_sh;
    logic signed [63:0]    mul_res;
    logic                  out_free;

    assign fold_d[0] = fold_axis(r_in.first_x, r_in.second_x, r_box[0], r_half[0]);
    assign fold_d[1] = fold_axis(r_in.first_y, r_in.second_y, r_box[1], r_half[1]);
    assign fold_d[2] = fold_axis(r_in.first_z, r_in.second_z, r_box[2], r_half[2]);

    assign d_sel = r_d[i_cmd.sel[1:0]];
    assign d_mag = d_sel[31] ? 31'(-d_sel) : d_sel[30:0];

    always_comb begin
        if (i_cmd.op == hpef_pkg::OP_SQUARE) begin
            mul_a = {1'b0, d_mag};
            mul_b = {1'b0, d_mag};
        end else begin
            mul_a = i_cmd.step[1] ? r_ma[63:32] : r_ma[31:0];
            mul_b = i_cmd.step[0] ? r_mb[63:32] : r_mb[31:0];
        end
    end

    assign mul_p = mul_a * mul_b;

    assign root_shift = 7'd62 - {1'b0, i_cmd.step, 1'b0};
    assign root_bit   = 64'd1 << root_shift;
    assign root_trial = r_root + root_bit;

    assign den     = r_root[31:0];
    assign div_src = i_cmd.first ? {3'b000, d_mag} : {r_drem[32:0], 1'b0};
    assign div_ge  = div_src >= {2'b00, den};
    assign div_rem = div_ge ? div_src - {2'b00, den} : div_src;
    assign div_q   = i_cmd.first ? Q_W'(div_ge) : {r_quot[Q_W-2:0], div_ge};

    always_comb begin
        if (den == 32'd0) begin
            div_u = '0;
        end else if (d_sel[31]) begin
            div_u = -signed'({1'b0, div_q});
        end else begin
            div_u = signed'({1'b0, div_q});
        end
    end

    assign rr = signed'({2'b00, r_root[31:0]}) - signed'({3'b000, r_in.rest_length});

    always_comb begin
        unique case (i_cmd.sel)
            hpef_pkg::JOB_KR: begin
                op_a = signed'({33'd0, r_in.spring_constant});
                op_b = 64'(rr);
            end
            hpef_pkg::JOB_EN: begin
                op_a = r_kr;
                op_b = 64'(rr);
            end
            hpef_pkg::JOB_FX: begin
                op_a = r_fr;
                op_b = 64'(r_u[0]);
            end
            hpef_pkg::JOB_FY: begin
                op_a = r_fr;
                op_b = 64'(r_u[1]);
            end
            hpef_pkg::JOB_FZ: begin
                op_a = r_fr;
                op_b = 64'(r_u[2]);
            end
            hpef_pkg::JOB_VXX: begin
                op_a = r_f[0];
                op_b = 64'(r_d[0]);
            end
            hpef_pkg::JOB_VYX: begin
                op_a = r_f[1];
                op_b = 64'(r_d[0]);
            end
            hpef_pkg::JOB_VYY: begin
                op_a = r_f[1];
                op_b = 64'(r_d[1]);
            end
            hpef_pkg::JOB_VZX: begin
                op_a = r_f[2];
                op_b = 64'(r_d[0]);
            end
            hpef_pkg::JOB_VZY: begin
                op_a = r_f[2];
                op_b = 64'(r_d[1]);
            end
            hpef_pkg::JOB_VZZ: begin
                op_a = r_f[2];
                op_b = 64'(r_d[2]);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign pp_shift = {i_cmd.step[1] & i_cmd.step[0], i_cmd.step[1] ^ i_cmd.step[0], 5'd0};

    assign prod_s  = r_mneg ? -signed'(r_acc) : signed'(r_acc);
    assign prod_sh = prod_s >>> FRACTION_BITS;

    always_comb begin
        if (prod_sh[127:63] == '0 || prod_sh[127:63] == '1) begin
            mul_res = prod_sh[63:0];
        end else begin
            mul_res = prod_sh[127] ? S64_MIN : S64_MAX;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_box[i]  <= '0;
                r_half[i] <= '0;
            end
            r_esum <= '0;
            for (int i = 0; i < 6; i++) begin
                r_vir[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    hpef_pkg::REG_BOX_X:  r_box[0]  <= i_cfg_data;
                    hpef_pkg::REG_BOX_Y:  r_box[1]  <= i_cfg_data;
                    hpef_pkg::REG_BOX_Z:  r_box[2]  <= i_cfg_data;
                    hpef_pkg::REG_HALF_X: r_half[0] <= i_cfg_data;
                    hpef_pkg::REG_HALF_Y: r_half[1] <= i_cfg_data;
                    hpef_pkg::REG_HALF_Z: r_half[2] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.op == hpef_pkg::OP_MUL_DONE) begin
                if (i_cmd.sel == hpef_pkg::JOB_EN) begin
                    r_esum <= sat_add(r_esum, mul_res);
                end else if (i_cmd.sel >= hpef_pkg::JOB_VXX) begin
                    r_vir[3'(i_cmd.sel - hpef_pkg::JOB_VXX)] <=
                        sat_add(r_vir[3'(i_cmd.sel - hpef_pkg::JOB_VXX)], mul_res);
                end
            end
            if (i_cmd.op == hpef_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
                if (r_in.last_pair) begin
                    r_esum <= '0;
                    for (int i = 0; i < 6; i++) begin
                        r_vir[i] <= '0;
                    end
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_in <= i_item;
        end
        unique case (i_cmd.op)
            hpef_pkg::OP_FOLD: begin
                for (int i = 0; i < 3; i++) begin
                    r_d[i] <= fold_d[i];
                end
                r_s    <= '0;
                r_root <= '0;
            end
            hpef_pkg::OP_SQUARE: begin
                r_s <= r_s + mul_p;
            end
            hpef_pkg::OP_ROOT: begin
                if (r_s >= root_trial) begin
                    r_s    <= r_s - root_trial;
                    r_root <= (r_root >> 1) + root_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
            end
            hpef_pkg::OP_DIVIDE: begin
                r_drem <= div_rem;
                r_quot <= div_q;
                if (i_cmd.last) begin
                    r_u[i_cmd.sel[1:0]] <= div_u;
                end
            end
            hpef_pkg::OP_MUL_LOAD: begin
                r_ma   <= mag64(op_a);
                r_mb   <= mag64(op_b);
                r_mneg <= op_a[63] ^ op_b[63];
                r_acc  <= '0;
            end
            hpef_pkg::OP_MUL_STEP: begin
                r_acc <= r_acc + (128'(mul_p) << pp_shift);
            end
            hpef_pkg::OP_MUL_DONE: begin
                if (i_cmd.sel == hpef_pkg::JOB_KR) begin
                    r_kr <= mul_res;
                    r_fr <= sat_neg(sat_add(mul_res, mul_res));
                end else if (i_cmd.sel == hpef_pkg::JOB_FX) begin
                    r_f[0] <= mul_res;
                end else if (i_cmd.sel == hpef_pkg::JOB_FY) begin
                    r_f[1] <= mul_res;
                end else if (i_cmd.sel == hpef_pkg::JOB_FZ) begin
                    r_f[2] <= mul_res;
                end
            end
            hpef_pkg::OP_EMIT: begin
                r_out.force_x      <= r_f[0];
                r_out.force_y      <= r_f[1];
                r_out.force_z      <= r_f[2];
                r_out.energy_total <= r_esum;
                r_out.virial_xx    <= r_vir[0];
                r_out.virial_yx    <= r_vir[1];
                r_out.virial_yy    <= r_vir[2];
                r_out.virial_zx    <= r_vir[3];
                r_out.virial_zy    <= r_vir[4];
                r_out.virial_zz    <= r_vir[5];
                r_out.set_done     <= r_in.last_pair;
            end
            default: begin
            end
        endcase
    end

    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out;

endmodule
`default_nettype wire

// ===== hw/rtl/hpef_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Harmonic pair controller
// Sequences folding, squaring, square root, division and the multiply jobs
// of one pair, then hands the result to the output register.
// ----------------------------------------------------------------------------
module hpef_ctrl #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_load,
    output hpef_pkg::t_cmd         o_cmd,
    input  wire hpef_pkg::t_status i_status
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_FOLD     = 7'b0000010,
        ST_SQUARE   = 7'b0000100,
        ST_ROOT     = 7'b0001000,
        ST_DIVIDE   = 7'b0010000,
        ST_MULTIPLY = 7'b0100000,
        ST_EMIT     = 7'b1000000
    } t_state;

    localparam logic [4:0] PH_LOAD = 5'd0;
    localparam logic [4:0] PH_DONE = 5'd5;
    localparam logic [4:0] DIV_LAST = 5'(FRACTION_BITS);

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [3:0] r_sel, n_sel;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_sel       = r_sel;
        o_load      = 1'b0;
        o_cmd.op    = hpef_pkg::OP_NONE;
        o_cmd.sel   = r_sel;
        o_cmd.step  = r_cnt;
        o_cmd.first = (r_cnt == 5'd0);
        o_cmd.last  = (r_cnt == DIV_LAST);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_load  = 1'b1;
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                o_cmd.op = hpef_pkg::OP_FOLD;
                n_sel    = hpef_pkg::AXIS_X;
                n_state  = ST_SQUARE;
            end
            ST_SQUARE: begin
                o_cmd.op = hpef_pkg::OP_SQUARE;
                if (r_sel == hpef_pkg::AXIS_Z) begin
                    n_cnt   = 5'd0;
                    n_state = ST_ROOT;
                end else begin
                    n_sel = r_sel + 4'd1;
                end
            end
            ST_ROOT: begin
                o_cmd.op = hpef_pkg::OP_ROOT;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == hpef_pkg::ROOT_LAST) begin
                    n_cnt   = 5'd0;
                    n_sel   = hpef_pkg::AXIS_X;
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                o_cmd.op = hpef_pkg::OP_DIVIDE;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_cnt = 5'd0;
                    if (r_sel == hpef_pkg::AXIS_Z) begin
                        n_sel   = hpef_pkg::JOB_KR;
                        n_state = ST_MULTIPLY;
                    end else begin
                        n_sel = r_sel + 4'd1;
                    end
                end
            end
            ST_MULTIPLY: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == PH_LOAD) begin
                    o_cmd.op = hpef_pkg::OP_MUL_LOAD;
                end else if (r_cnt == PH_DONE) begin
                    o_cmd.op = hpef_pkg::OP_MUL_DONE;
                    n_cnt    = 5'd0;
                    if (r_sel == hpef_pkg::JOB_VZZ) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_sel = r_sel + 4'd1;
                    end
                end else begin
                    o_cmd.op   = hpef_pkg::OP_MUL_STEP;
                    o_cmd.step = r_cnt - 5'd1;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = hpef_pkg::OP_EMIT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule
`default_nettype wire

// ===== hw/rtl/harmonic_pair_energy_force_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Harmonic pair energy and force, top level
// One harmonic pair beat in, one force, energy and virial beat out.
// ----------------------------------------------------------------------------
// Each input beat is folded by the minimum image rule, its distance is taken
// by a 32-step square root, the unit vector by three divisions of
// FRACTION_BITS + 1 steps each, and eleven products of 64 by 64 bits are
// built on one shared 32 by 32 bit multiplier. One pair is worked on at a
// time; the next input beat is taken while a result still waits at the
// output. Running energy and virial sums clear after a beat marked last.
// Configuration writes are always ready and must be made while idle.
module harmonic_pair_energy_force_top #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire hpef_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output hpef_pkg::t_out_item       o_out_item,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire hpef_pkg::t_cfg_index i_cfg_index,
    input  wire logic [30:0]          i_cfg_data
);

    logic              load;
    hpef_pkg::t_cmd    cmd;
    hpef_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    hpef_ctrl #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_load     (load),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    hpef_datapath #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire
